### sv/cs_pkg.sv
// Shared character codes and word types for the comment stripper stream.
`timescale 1ns / 1ps

package cs_pkg;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        byte_t data;
        logic  last;
    } out_word_t;

    localparam byte_t CH_SEMI   = 8'h3B;
    localparam byte_t CH_SLASH  = 8'h2F;
    localparam byte_t CH_STAR   = 8'h2A;
    localparam byte_t CH_NL     = 8'h0A;
    localparam byte_t CH_DQUOTE = 8'h22;
    localparam byte_t CH_SQUOTE = 8'h27;

endpackage

### sv/comment_stripper_stream_top.sv
// Comment stripper: drops line, semicolon-tail and block comments from a byte stream.
//
//  channel | dir | tdata          | tlast              | tuser
//  s_      | in  | data_byte[7:0] | end_of_stream      | -
//  m_      | out | out_byte[7:0]  | last_of_run        | -
//
//  One input word is taken per cycle while s_tready is high; its zero, one or
//  two result words enter a three-word output queue in the cycle after acceptance.
//  s_tready is high while the queue holds at most one word, so a word that
//  gives two results can hold off the next input word while the output drains.
//  m_tvalid is high whenever the queue is not empty; m_tready low holds the head.
//  aresetn (synchronous, active low) returns the scanner to normal text and
//  empties the queue.
`timescale 1ns / 1ps

module comment_stripper_stream_top (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  cs_pkg::byte_t    s_tdata,   // [7:0] data_byte
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    output cs_pkg::byte_t    m_tdata,   // [7:0] out_byte
    output logic             m_tlast
);
    import cs_pkg::*;

    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_SLASH  = 3'd1,
        M_LINE   = 3'd2,
        M_BLOCK  = 3'd3,
        M_BSTAR  = 3'd4,
        M_QUOTE  = 3'd5
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic        quote_dbl_reg, quote_dbl_next;
    logic [1:0]  cnt_reg, cnt_next;
    out_word_t   buf_reg [3];
    out_word_t   buf_next [3];

    logic        push;
    logic        pop;
    logic [1:0]  n_res;
    byte_t       res0, res1;
    logic [1:0]  base;
    out_word_t   shifted [3];

    assign s_tready = (cnt_reg <= 2'd1);
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = buf_reg[0].data;
    assign m_tlast  = buf_reg[0].last;
    assign push     = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    always_comb begin
        mode_next      = mode_reg;
        quote_dbl_next = quote_dbl_reg;
        n_res          = 2'd0;
        res0           = s_tdata;
        res1           = s_tdata;
        if (s_tlast) begin
            if (mode_reg == M_SLASH) begin
                n_res = 2'd1;
                res0  = CH_SLASH;
            end
            mode_next      = M_NORMAL;
            quote_dbl_next = 1'b0;
        end else begin
            case (mode_reg)
                M_SLASH: begin
                    if (s_tdata == CH_SLASH) begin
                        mode_next = M_LINE;
                    end else if (s_tdata == CH_STAR) begin
                        mode_next = M_BLOCK;
                    end else begin
                        res0 = CH_SLASH;
                        res1 = s_tdata;
                        case (s_tdata)
                            CH_SEMI: begin
                                n_res     = 2'd2;
                                mode_next = M_LINE;
                            end
                            CH_DQUOTE, CH_SQUOTE: begin
                                n_res          = 2'd2;
                                quote_dbl_next = (s_tdata == CH_DQUOTE);
                                mode_next      = M_QUOTE;
                            end
                            default: begin
                                n_res     = 2'd2;
                                mode_next = M_NORMAL;
                            end
                        endcase
                    end
                end
                M_LINE: begin
                    if (s_tdata == CH_NL) begin
                        n_res     = 2'd1;
                        mode_next = M_NORMAL;
                    end
                end
                M_BLOCK: begin
                    if (s_tdata == CH_NL) begin
                        n_res = 2'd1;
                    end else if (s_tdata == CH_STAR) begin
                        mode_next = M_BSTAR;
                    end
                end
                M_BSTAR: begin
                    if (s_tdata == CH_SLASH) begin
                        mode_next = M_NORMAL;
                    end else if (s_tdata != CH_STAR) begin
                        if (s_tdata == CH_NL) begin
                            n_res = 2'd1;
                        end
                        mode_next = M_BLOCK;
                    end
                end
                M_QUOTE: begin
                    n_res = 2'd1;
                    if (s_tdata == CH_NL ||
                        s_tdata == (quote_dbl_reg ? CH_DQUOTE : CH_SQUOTE)) begin
                        mode_next = M_NORMAL;
                    end
                end
                default: begin
                    case (s_tdata)
                        CH_SEMI: begin
                            n_res     = 2'd1;
                            mode_next = M_LINE;
                        end
                        CH_SLASH: begin
                            mode_next = M_SLASH;
                        end
                        CH_DQUOTE, CH_SQUOTE: begin
                            n_res          = 2'd1;
                            quote_dbl_next = (s_tdata == CH_DQUOTE);
                            mode_next      = M_QUOTE;
                        end
                        default: begin
                            n_res     = 2'd1;
                            mode_next = M_NORMAL;
                        end
                    endcase
                end
            endcase
        end
    end

    always_comb begin
        if (pop) begin
            shifted[0] = buf_reg[1];
            shifted[1] = buf_reg[2];
            shifted[2] = buf_reg[2];
        end else begin
            shifted = buf_reg;
        end
        base     = cnt_reg - {1'b0, pop};
        buf_next = shifted;
        cnt_next = base;
        if (push) begin
            cnt_next = base + n_res;
            for (int i = 0; i < 3; i++) begin
                if (n_res != 2'd0 && 2'(i) == base) begin
                    buf_next[i].data = res0;
                    buf_next[i].last = (n_res == 2'd1);
                end
                if (n_res == 2'd2 && 2'(i) == base + 2'd1) begin
                    buf_next[i].data = res1;
                    buf_next[i].last = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= M_NORMAL;
            quote_dbl_reg <= 1'b0;
            cnt_reg       <= 2'd0;
        end else begin
            if (push) begin
                mode_reg      <= mode_next;
                quote_dbl_reg <= quote_dbl_next;
            end
            cnt_reg <= cnt_next;
        end
        buf_reg <= buf_next;
    end

    a_eos_returns_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        push && s_tlast |=> mode_reg == M_NORMAL && !quote_dbl_reg)
        else $error("end of stream did not return scanner to normal");

    a_two_results_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        push && n_res == 2'd2 |=> cnt_reg >= 2'd2)
        else $error("two-word result not queued");

    a_pending_slash_flushed: assert property (@(posedge aclk) disable iff (!aresetn)
        push && s_tlast && mode_reg == M_SLASH |=> m_tvalid)
        else $error("pending slash lost at end of stream");

    a_queue_not_over_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd3 |=> cnt_reg >= 2'd2)
        else $error("output queue drained by more than one word");

endmodule
